FILE: hdl/dcts_pkg.sv
// Package: constants and types for the dependency-counting task scheduler.
package dcts_pkg;
	localparam int BLOCK_ENTRIES = 16;
	localparam int WAIT_DEPTH    = 8;
	localparam int QUEUE_DEPTH   = 64;
	localparam int NUM_CLASSES   = 2;
	localparam int HANDLE_BITS   = 16;

	localparam int NENT   = BLOCK_ENTRIES * NUM_CLASSES;
	localparam int EIDX_W = $clog2(NENT);
	localparam int BIDX_W = $clog2(BLOCK_ENTRIES);
	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int WIDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int WLEN_W = $clog2(WAIT_DEPTH + 1);
	localparam int QIDX_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int WADDR_W = $clog2(NENT * WAIT_DEPTH);
	localparam int RADDR_W = $clog2(NUM_CLASSES * QUEUE_DEPTH);
	localparam logic [7:0] COUNT_MAX = 8'd255;

	localparam logic [2:0] REQ_DECLARE = 3'd0;
	localparam logic [2:0] REQ_SUBMIT  = 3'd1;
	localparam logic [2:0] REQ_GET     = 3'd2;
	localparam logic [2:0] REQ_RELEASE = 3'd3;
	localparam logic [2:0] REQ_QUERY   = 3'd4;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TABLE_FULL = 3'd1;
	localparam logic [2:0] ST_WAIT_FULL  = 3'd2;
	localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
	localparam logic [2:0] ST_UNKNOWN    = 3'd4;
	localparam logic [2:0] ST_COUNT_FULL = 3'd5;

	typedef struct packed {
		logic                  start;
		logic                  cls0;
		logic [CLS_W-1:0]      cls;
		logic [31:0]           key;
	} srch_req_t;

	typedef struct packed {
		logic                  done;
		logic                  hit;
		logic [EIDX_W-1:0]     hit_idx;
		logic                  free;
		logic [EIDX_W-1:0]     free_idx;
	} srch_rsp_t;
endpackage

FILE: hdl/dcts_ram.sv
// Generic single-port-write, registered-read RAM.
module dcts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hdl/dcts_search.sv
// Block table search: walks one class's entries one per cycle with a shared comparator.
module dcts_search import dcts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srch_req_t             req,
	input  logic [NENT-1:0]       valid,
	output logic [EIDX_W-1:0]     key_raddr,
	input  logic [31:0]           key_rdata,
	output srch_rsp_t             rsp
);
	logic                  busy_q, rdv_q, hit_q, free_q, done_q;
	logic [BIDX_W:0]       cnt_q;
	logic [EIDX_W-1:0]     base_q, cur_q, hit_idx_q, free_idx_q;
	logic [31:0]           key_q;
	logic [EIDX_W-1:0]     base_d;

	assign base_d = req.cls0 ? '0 : EIDX_W'(int'(req.cls) * BLOCK_ENTRIES);
	assign key_raddr = busy_q ? EIDX_W'(base_q + EIDX_W'(cnt_q)) : base_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rdv_q  <= 1'b0;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				rdv_q  <= 1'b0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				cnt_q  <= '0;
				base_q <= base_d;
				key_q  <= req.key;
			end else if (busy_q) begin
				if (cnt_q < (BIDX_W+1)'(BLOCK_ENTRIES)) cnt_q <= cnt_q + 1'b1;
				rdv_q <= cnt_q < (BIDX_W+1)'(BLOCK_ENTRIES);
				cur_q <= key_raddr;
				if (rdv_q) begin
					if (valid[cur_q] && key_rdata == key_q && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= cur_q;
					end
					if (!valid[cur_q] && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= cur_q;
					end
					if (cur_q == EIDX_W'(base_q + EIDX_W'(BLOCK_ENTRIES - 1))) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.hit      = hit_q;
	assign rsp.hit_idx  = hit_idx_q;
	assign rsp.free     = free_q;
	assign rsp.free_idx = free_idx_q;
endmodule

FILE: hdl/dependency_counting_task_scheduler.sv
// Top level of the dependency-counting task scheduler.
// Requests arrive as beats on the s_axis channel; each gives exactly one
// result beat on m_axis. s_tdata: req_type[2:0], queue_type[3],
// task_handle[19:4], block_id[51:20]. m_tdata: status[2:0],
// task_out[18:3], task_valid[19], is_blocked[20].
// One request is worked at a time: s_tready is low from acceptance until
// the result beat has left the output register. A table walk makes one key
// compare per cycle through the key RAM port; a get reads the ready RAM, and
// a release that frees an entry moves each waiting handle through the wait
// RAM into the ready RAM before the result beat is offered.
// With m_tready high the next request can be taken in the cycle after the
// result beat is accepted.
// The result waits in the output register while m_tready is low; no new
// request is taken until it has gone.
// Reset clears valid bits, wait lengths and FIFO pointers at once; the
// RAM contents are not cleared and are read only behind those marks.
module dependency_counting_task_scheduler import dcts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // req_type, queue_type, task_handle, block_id
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // status, task_out, task_valid, is_blocked
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SRCH = 7'b0000010,
		S_GETR = 7'b0000100,
		S_MOVR = 7'b0001000,
		S_MOVW = 7'b0010000,
		S_OUT  = 7'b0100000,
		S_GETW = 7'b1000000
	} state_t;

	state_t state_q;
	logic [2:0]             req_q;
	logic [CLS_W-1:0]       cls_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [31:0]            key_q;
	logic [NENT-1:0]        valid_q;
	logic [WLEN_W-1:0]      wlen_q [NENT];
	logic [7:0]             cnt_q [NENT];
	logic [QIDX_W-1:0]      head_q [NUM_CLASSES];
	logic [QCNT_W-1:0]      fill_q [NUM_CLASSES];
	logic [EIDX_W-1:0]      ent_q;
	logic [WLEN_W-1:0]      mv_q;
	logic                   ov_q;
	logic [23:0]            res_q;

	logic [2:0]  res_st;
	logic [15:0] res_to;
	logic        res_tv, res_bl, res_ld;

	srch_req_t sreq;
	srch_rsp_t srsp;
	logic [EIDX_W-1:0] key_raddr;
	logic [31:0] key_rdata;
	logic key_we;
	logic [EIDX_W-1:0] key_waddr;

	logic w_we;
	logic [WADDR_W-1:0] w_waddr, w_raddr;
	logic [HANDLE_BITS-1:0] w_rdata;
	logic r_we;
	logic [RADDR_W-1:0] r_waddr, r_raddr;
	logic [HANDLE_BITS-1:0] r_wdata, r_rdata;

	logic [CLS_W-1:0] cls_d;
	logic [QIDX_W-1:0] tail;
	logic [QCNT_W:0] need;

	assign cls_d = CLS_W'(int'(s_tdata[3]) % NUM_CLASSES);
	assign s_tready = (state_q == S_IDLE) && !ov_q;
	assign m_tvalid = ov_q;
	assign m_tdata  = res_q;

	assign sreq.start = s_tvalid && s_tready;
	assign sreq.cls0  = (s_tdata[2:0] == REQ_QUERY);
	assign sreq.cls   = cls_d;
	assign sreq.key   = s_tdata[51:20];

	dcts_search u_search (
		.clk(clk), .arst_n(arst_n), .req(sreq), .valid(valid_q),
		.key_raddr(key_raddr), .key_rdata(key_rdata), .rsp(srsp)
	);

	dcts_ram #(.WIDTH(32), .DEPTH(NENT)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_q),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	dcts_ram #(.WIDTH(HANDLE_BITS), .DEPTH(NENT * WAIT_DEPTH)) u_wait_ram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(hnd_q),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	dcts_ram #(.WIDTH(HANDLE_BITS), .DEPTH(NUM_CLASSES * QUEUE_DEPTH)) u_ready_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	assign tail = QIDX_W'((int'(head_q[cls_q]) + int'(fill_q[cls_q])) % QUEUE_DEPTH);
	assign need = (QCNT_W+1)'(fill_q[cls_q]) + (QCNT_W+1)'(wlen_q[srsp.hit_idx]);
	assign w_raddr = WADDR_W'(int'(ent_q) * WAIT_DEPTH + int'(mv_q));
	assign r_raddr = RADDR_W'(int'(cls_q) * QUEUE_DEPTH + int'(head_q[cls_q]));
	assign r_waddr = RADDR_W'(int'(cls_q) * QUEUE_DEPTH + int'(tail));

	always_comb begin
		key_we  = 1'b0;
		key_waddr = srsp.free_idx;
		w_we    = 1'b0;
		w_waddr = WADDR_W'(int'(srsp.hit_idx) * WAIT_DEPTH
			+ int'(wlen_q[srsp.hit_idx]));
		r_we    = 1'b0;
		r_wdata = hnd_q;
		res_ld  = 1'b0;
		res_st  = ST_OK;
		res_to  = '0;
		res_tv  = 1'b0;
		res_bl  = 1'b0;
		case (state_q)
			S_SRCH: begin
				if (srsp.done) begin
					res_ld = 1'b1;
					case (req_q)
						REQ_DECLARE: begin
							if (srsp.hit) begin
								if (cnt_q[srsp.hit_idx] >= COUNT_MAX) res_st = ST_COUNT_FULL;
							end else if (!srsp.free) res_st = ST_TABLE_FULL;
							else key_we = 1'b1;
						end
						REQ_SUBMIT: begin
							if (srsp.hit) begin
								if (wlen_q[srsp.hit_idx] >= WLEN_W'(WAIT_DEPTH))
									res_st = ST_WAIT_FULL;
								else w_we = 1'b1;
							end else if (fill_q[cls_q] >= QCNT_W'(QUEUE_DEPTH))
								res_st = ST_QUEUE_FULL;
							else r_we = 1'b1;
						end
						REQ_RELEASE: begin
							if (!srsp.hit) res_st = ST_UNKNOWN;
							else if (cnt_q[srsp.hit_idx] <= 8'd1) begin
								if (need > (QCNT_W+1)'(QUEUE_DEPTH)) res_st = ST_QUEUE_FULL;
								else res_ld = 1'b0;
							end
						end
						REQ_QUERY: res_bl = srsp.hit;
						default: ;
					endcase
				end
			end
			S_GETW: begin
				res_ld = 1'b1;
				res_to = 16'(r_rdata);
				res_tv = 1'b1;
			end
			S_MOVW: begin
				r_we    = 1'b1;
				r_wdata = w_rdata;
			end
			S_OUT: res_ld = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
			valid_q <= '0;
			for (int i = 0; i < NENT; i++) wlen_q[i] <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				fill_q[c] <= '0;
			end
		end else begin
			if (m_tvalid && m_tready) ov_q <= 1'b0;
			if (res_ld) begin
				ov_q  <= 1'b1;
				res_q <= {3'b000, res_bl, res_tv, res_to, res_st};
			end
			if (r_we) fill_q[cls_q] <= fill_q[cls_q] + 1'b1;
			if (w_we) wlen_q[srsp.hit_idx] <= wlen_q[srsp.hit_idx] + 1'b1;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						req_q <= s_tdata[2:0];
						cls_q <= cls_d;
						hnd_q <= s_tdata[4 +: HANDLE_BITS];
						key_q <= s_tdata[51:20];
						state_q <= (s_tdata[2:0] == REQ_GET) ? S_GETR : S_SRCH;
					end
				end
				S_SRCH: begin
					if (srsp.done) begin
						state_q <= S_IDLE;
						ent_q <= srsp.hit_idx;
						mv_q  <= '0;
						case (req_q)
							REQ_DECLARE: begin
								if (srsp.hit) begin
									if (cnt_q[srsp.hit_idx] < COUNT_MAX)
										cnt_q[srsp.hit_idx] <= cnt_q[srsp.hit_idx] + 1'b1;
								end else if (srsp.free) begin
									valid_q[srsp.free_idx] <= 1'b1;
									cnt_q[srsp.free_idx]   <= 8'd1;
									wlen_q[srsp.free_idx]  <= '0;
								end
							end
							REQ_RELEASE: begin
								if (srsp.hit) begin
									if (cnt_q[srsp.hit_idx] > 8'd1)
										cnt_q[srsp.hit_idx] <= cnt_q[srsp.hit_idx] - 1'b1;
									else if (need <= (QCNT_W+1)'(QUEUE_DEPTH))
										state_q <= S_MOVR;
								end
							end
							default: ;
						endcase
					end
				end
				S_GETR: begin
					if (fill_q[cls_q] != '0) state_q <= S_GETW;
					else state_q <= S_OUT;
				end
				S_GETW: begin
					head_q[cls_q] <= QIDX_W'((int'(head_q[cls_q]) + 1) % QUEUE_DEPTH);
					fill_q[cls_q] <= fill_q[cls_q] - 1'b1;
					state_q <= S_IDLE;
				end
				S_MOVR: begin
					if (mv_q == wlen_q[ent_q]) begin
						valid_q[ent_q] <= 1'b0;
						wlen_q[ent_q]  <= '0;
						state_q <= S_OUT;
					end else state_q <= S_MOVW;
				end
				S_MOVW: begin
					mv_q <= mv_q + 1'b1;
					state_q <= S_MOVR;
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: bench/dcts_checker.sv
// Checker: predicts each scheduler result and compares it with the output beats.
module dcts_checker import dcts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] task_out;
		logic        task_valid;
		logic        is_blocked;
	} sched_result_t;

	logic        ent_valid [NENT];
	logic [31:0] ent_key [NENT];
	int          ent_count [NENT];
	int          ent_wlen [NENT];
	logic [15:0] ent_waiters [NENT][WAIT_DEPTH];
	logic [15:0] ready_fifo [NUM_CLASSES][$];
	sched_result_t expected_results [$];

	assign pending = expected_results.size();

	function automatic int lookup_block(int cls, logic [31:0] key);
		for (int i = 0; i < BLOCK_ENTRIES; i++)
			if (ent_valid[cls*BLOCK_ENTRIES+i] && ent_key[cls*BLOCK_ENTRIES+i] == key)
				return cls*BLOCK_ENTRIES+i;
		return -1;
	endfunction

	function automatic sched_result_t schedule_request(logic [55:0] d);
		sched_result_t r;
		logic [2:0] req;
		int cls, e, fr;
		logic [15:0] h;
		logic [31:0] key;
		r = '0;
		req = d[2:0];
		cls = int'(d[3]) % NUM_CLASSES;
		h = d[19:4];
		key = d[51:20];
		case (req)
			REQ_DECLARE: begin
				e = lookup_block(cls, key);
				if (e >= 0) begin
					if (ent_count[e] >= COUNT_MAX) r.status = ST_COUNT_FULL;
					else ent_count[e]++;
				end else begin
					fr = -1;
					for (int i = BLOCK_ENTRIES - 1; i >= 0; i--)
						if (!ent_valid[cls*BLOCK_ENTRIES+i]) fr = cls*BLOCK_ENTRIES+i;
					if (fr < 0) r.status = ST_TABLE_FULL;
					else begin
						ent_valid[fr] = 1;
						ent_key[fr] = key;
						ent_count[fr] = 1;
						ent_wlen[fr] = 0;
					end
				end
			end
			REQ_SUBMIT: begin
				e = lookup_block(cls, key);
				if (e >= 0) begin
					if (ent_wlen[e] >= WAIT_DEPTH) r.status = ST_WAIT_FULL;
					else begin
						ent_waiters[e][ent_wlen[e]] = h;
						ent_wlen[e]++;
					end
				end else if (ready_fifo[cls].size() >= QUEUE_DEPTH) r.status = ST_QUEUE_FULL;
				else ready_fifo[cls] = {ready_fifo[cls], h};
			end
			REQ_GET: begin
				if (ready_fifo[cls].size() > 0) begin
					r.task_out = ready_fifo[cls].pop_front();
					r.task_valid = 1;
				end
			end
			REQ_RELEASE: begin
				e = lookup_block(cls, key);
				if (e < 0) r.status = ST_UNKNOWN;
				else if (ent_count[e] <= 1) begin
					if (ready_fifo[cls].size() + ent_wlen[e] > QUEUE_DEPTH)
						r.status = ST_QUEUE_FULL;
					else begin
						for (int j = 0; j < ent_wlen[e]; j++)
							ready_fifo[cls] = {ready_fifo[cls], ent_waiters[e][j]};
						ent_valid[e] = 0;
						ent_wlen[e] = 0;
					end
				end else ent_count[e]--;
			end
			REQ_QUERY: r.is_blocked = (lookup_block(0, key) >= 0);
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		for (int i = 0; i < NENT; i++) begin
			ent_valid[i] = 0;
			ent_wlen[i] = 0;
		end
	end

	always @(posedge clk) begin
		sched_result_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_results = {expected_results, schedule_request(s_tdata)};
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[2:0];
				got.task_out = m_tdata[18:3];
				got.task_valid = m_tdata[19];
				got.is_blocked = m_tdata[20];
				if (expected_results.size() == 0)
					report_mismatch("unexpected beat", 1, 0);
				else begin
					want = expected_results.pop_front();
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
					if (got.task_out != want.task_out)
						report_mismatch("task_out", got.task_out, want.task_out);
					if (got.task_valid != want.task_valid)
						report_mismatch("task_valid", got.task_valid, want.task_valid);
					if (got.is_blocked != want.is_blocked)
						report_mismatch("is_blocked", got.is_blocked, want.is_blocked);
				end
			end
		end
	end
endmodule

FILE: bench/tb_dependency_counting_task_scheduler.sv
// Testbench top: request stimulus, idling, and the verdict for the scheduler.
module tb_dependency_counting_task_scheduler;
	import dcts_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [23:0] m_tdata;
	int          fail_count, pending;
	int          beats_sent = 0;
	bit          calm = 0;
	int          hold_cycles = 0;
	logic [31:0] key_pool [8];

	always #5 clk = ~clk;

	dependency_counting_task_scheduler dut (.*);

	dcts_checker chk (.*);

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 0;
		end else
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
	end

	task automatic send(logic [2:0] req, logic cls, logic [15:0] h, logic [31:0] key);
		while (!calm && $urandom_range(99) < 13) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {4'b0, key, h, cls, req};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
	endtask

	function automatic logic [31:0] pick_key();
		return ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(7)];
	endfunction

	initial begin
		int k;
		for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed corner cases
		send(REQ_GET, 0, 0, 0);
		send(REQ_RELEASE, 1, 0, 32'h1234);
		send(REQ_DECLARE, 0, 16'hFFFF, 32'hFFFF_FFFF);
		send(REQ_QUERY, 1, 0, 32'hFFFF_FFFF);
		send(REQ_SUBMIT, 0, 16'hFFFF, 32'hFFFF_FFFF);
		send(REQ_SUBMIT, 0, 16'h0000, 32'h0);
		send(REQ_DECLARE, 0, 0, 32'hFFFF_FFFF);
		send(REQ_RELEASE, 0, 0, 32'hFFFF_FFFF);
		send(REQ_RELEASE, 0, 0, 32'hFFFF_FFFF);
		send(REQ_GET, 0, 0, 0);
		send(REQ_GET, 0, 0, 0);
		send(3'd5, 1, 16'hA5A5, 32'h5A5A_5A5A);
		send(3'd6, 0, 0, 0);
		send(3'd7, 1, 16'hFFFF, 32'hFFFF_FFFF);
		// table full in class 1, then wait list full
		for (int i = 0; i <= BLOCK_ENTRIES; i++) send(REQ_DECLARE, 1, 0, 32'h100 + i);
		for (int i = 0; i <= WAIT_DEPTH; i++) send(REQ_SUBMIT, 1, 16'(i), 32'h100);
		// count saturation on one id
		for (int i = 0; i < 256; i++) send(REQ_DECLARE, 0, 0, 32'h77);
		// ready FIFO full, full release rejected
		for (int i = 0; i <= QUEUE_DEPTH; i++) send(REQ_SUBMIT, 1, 16'($urandom), 32'h9999);
		send(REQ_RELEASE, 1, 0, 32'h100);
		for (int i = 0; i < QUEUE_DEPTH; i++) send(REQ_GET, 1, 0, 0);
		send(REQ_RELEASE, 1, 0, 32'h100);
		for (int i = 1; i <= BLOCK_ENTRIES; i++) send(REQ_RELEASE, 1, 0, 32'h100 + i);
		// long receiver hold-off while requests keep coming
		hold_cycles = 300;
		for (int i = 0; i < 6; i++) send(REQ_QUERY, 0, 0, key_pool[i]);
		// sender pause until drained
		s_tvalid <= 0;
		@(posedge clk);
		wait (pending == 0);
		calm = 1;
		for (int i = 0; i < 60; i++) begin
			k = $urandom_range(99);
			send(k < 25 ? REQ_DECLARE : k < 55 ? REQ_SUBMIT : k < 75 ? REQ_GET :
				k < 93 ? REQ_RELEASE : k < 98 ? REQ_QUERY : 3'($urandom_range(5, 7)),
				1'($urandom), 16'($urandom), pick_key());
		end
		calm = 0;
		for (int i = 0; i < 240; i++) begin
			k = $urandom_range(99);
			send(k < 25 ? REQ_DECLARE : k < 55 ? REQ_SUBMIT : k < 75 ? REQ_GET :
				k < 93 ? REQ_RELEASE : k < 98 ? REQ_QUERY : 3'($urandom_range(5, 7)),
				1'($urandom), 16'($urandom), pick_key());
		end
		s_tvalid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("Sent %0d requests: declare/submit/get/release/query, table, wait, FIFO", beats_sent);
		$display("and count limits, unused codes, long output stall and drained pauses.");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: dependency_counting_task_scheduler.f
hdl/dcts_pkg.sv
hdl/dcts_ram.sv
hdl/dcts_search.sv
hdl/dependency_counting_task_scheduler.sv
bench/dcts_checker.sv
bench/tb_dependency_counting_task_scheduler.sv
